// ===== design/bounded_list_insert_delete_top_macros.svh =====
// Assertion macros shared by the bounded list design
`ifndef BOUNDED_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define BOUNDED_LIST_INSERT_DELETE_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define BLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bounded list: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted
`define BLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bounded list: next-cycle check failed");

`endif

// ===== design/bli_pkg.sv =====
// Package: sizes, request codes, FSM states and control structs of the bounded list
package bli_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = 6;
    localparam int VAL_W      = 32;
    localparam int REQ_W      = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LIST
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic update;    // apply the request to the list
        logic load_out;  // load the next listing entry into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic listing_last;  // entry under the read index is the final one
    } status_t;

endpackage

// ===== design/bli_ctrl.sv =====
// Controller: request sequencing and output handshake for the bounded list
module bli_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  bli_pkg::status_t status,
    output bli_pkg::cmd_t    cmd
);
    import bli_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // Output slot can take a new item when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_LIST;
            end
            ST_LIST: begin
                if (out_free && status.listing_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            ST_LIST: begin
                cmd.load_out = out_free;
            end
            default: ;
        endcase
    end

    // Output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out)  m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== design/bli_datapath.sv =====
// Datapath: list storage, entry count, request registers and output register
module bli_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bli_pkg::cmd_t                       cmd,
    output bli_pkg::status_t                    status,
    input  logic [bli_pkg::REQ_W-1:0]           s_req_type,
    input  logic signed [bli_pkg::VAL_W-1:0]    s_entry_value,
    input  logic [bli_pkg::POS_W-1:0]           s_position,
    output logic signed [bli_pkg::VAL_W-1:0]    m_elem_value,
    output logic                                m_last_flag,
    output logic                                m_list_empty,
    output logic                                m_insert_dropped
);
    import bli_pkg::*;

    // Request registers
    logic [REQ_W-1:0]        type_reg;
    logic [VAL_W-1:0]        val_reg;
    logic [POS_W-1:0]        pos_reg;

    // List state
    logic [VAL_W-1:0]        entries_reg  [LIST_DEPTH];
    logic [VAL_W-1:0]        entries_next [LIST_DEPTH];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    dropped_reg, dropped_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;

    // Output register
    logic [VAL_W-1:0]        elem_reg;
    logic                    last_reg, empty_reg, drop_out_reg;

    logic                    full;
    logic                    del_ok;
    logic [IDX_W-1:0]        pos_idx;
    logic                    list_is_empty;

    assign full          = (count_reg == CNT_W'(LIST_DEPTH));
    assign del_ok        = ({1'b0, pos_reg} < (POS_W + 1)'(count_reg));
    assign pos_idx       = pos_reg[IDX_W-1:0];
    assign list_is_empty = (count_reg == '0);

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            type_reg <= s_req_type;
            val_reg  <= s_entry_value;
            pos_reg  <= s_position;
        end
    end

    // List update: shift toward the back, append, or close a gap; an insert into a full list only sets the drop flag
    always_comb begin
        entries_next = entries_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.update) begin
            dropped_next = 1'b0;
            case (type_reg)
                REQ_INS_FRONT: begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        entries_next[0] = val_reg;
                        for (int i = 1; i < LIST_DEPTH; i++) begin
                            entries_next[i] = entries_reg[i-1];
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_INS_BACK: begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        entries_next[count_reg[IDX_W-1:0]] = val_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_DELETE: begin
                    if (del_ok) begin
                        for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                            if (IDX_W'(i) >= pos_idx) entries_next[i] = entries_reg[i+1];
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        entries_reg <= entries_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            idx_reg     <= idx_next;
        end
    end

    // Listing read index
    always_comb begin
        idx_next = idx_reg;
        if (cmd.update)        idx_next = '0;
        else if (cmd.load_out) idx_next = IDX_W'(idx_reg + 1'b1);
    end

    assign status.listing_last = list_is_empty ||
                                 ((CNT_W'(idx_reg) + 1'b1) == count_reg);

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            elem_reg     <= list_is_empty ? '0 : entries_reg[idx_reg];
            last_reg     <= status.listing_last;
            empty_reg    <= list_is_empty;
            drop_out_reg <= dropped_reg;
        end
    end

    assign m_elem_value     = elem_reg;
    assign m_last_flag      = last_reg;
    assign m_list_empty     = empty_reg;
    assign m_insert_dropped = drop_out_reg;

endmodule

// ===== design/bounded_list_insert_delete_top.sv =====
// Top level of the bounded ordered list with front/back insert and indexed delete
// Holds up to 32 signed 32-bit entries in order. Each request (insert at front,
// append at back, delete at a position) is accepted, applied to the register
// array in the next cycle, and the whole list is then streamed out front to back,
// one item a cycle while m_ready is high, with m_last_flag on the final item; an
// empty list gives one item with m_list_empty set and zero value. An insert into a
// full list leaves the list as it is and sets m_insert_dropped on every item of
// that listing. The next request is taken while the last item of the previous
// listing still waits.
module bounded_list_insert_delete_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bli_pkg::REQ_W-1:0]           s_req_type,
    input  logic signed [bli_pkg::VAL_W-1:0]    s_entry_value,
    input  logic [bli_pkg::POS_W-1:0]           s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bli_pkg::VAL_W-1:0]    m_elem_value,
    output logic                                m_last_flag,
    output logic                                m_list_empty,
    output logic                                m_insert_dropped
);
    import bli_pkg::*;

    cmd_t    cmd;
    status_t status;

    bli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bli_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_req_type       (s_req_type),
        .s_entry_value    (s_entry_value),
        .s_position       (s_position),
        .m_elem_value     (m_elem_value),
        .m_last_flag      (m_last_flag),
        .m_list_empty     (m_list_empty),
        .m_insert_dropped (m_insert_dropped)
    );

`include "bounded_list_insert_delete_top_macros.svh"

    // An accepted item is applied to the list in the following cycle
    `BLI_ASSERT_NEXT(a_accept_then_update, aclk, aresetn, s_valid && s_ready, cmd.update)
    // An empty listing is a single zero item
    `BLI_ASSERT_IMPL(a_empty_single, aclk, aresetn, m_valid && m_list_empty, m_last_flag && (m_elem_value == '0))
    // No new request is taken while a listing is being loaded
    `BLI_ASSERT_IMPL(a_no_accept_in_list, aclk, aresetn, cmd.load_out, !s_ready)

endmodule

// ===== bench/bounded_list_insert_delete_top_test.sv =====
// Self-checking testbench for the bounded list: predicts every listing and checks each result
`timescale 1ns / 1ps

module bounded_list_insert_delete_top_test;
    import bli_pkg::*;

    // req_type code the block leaves unused
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_CAP    = 30;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    empty;
        logic                    dropped;
    } listing_entry_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [REQ_W-1:0]        s_req_type = '0;
    logic signed [VAL_W-1:0] s_entry_value = '0;
    logic [POS_W-1:0]        s_position = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [VAL_W-1:0] m_elem_value;
    logic                    m_last_flag;
    logic                    m_list_empty;
    logic                    m_insert_dropped;

    // predictor state and the listings still owed by the block
    logic signed [VAL_W-1:0] list_model[$];
    listing_entry_t          listing_q[$];

    int  items_sent = 0;
    int  results_checked = 0;
    int  mismatch_count = 0;
    int  drops_predicted = 0;
    int  peak_count = 0;
    int  idle_cycles = 0;
    bit  tx_gaps = 1'b0;
    bit  rx_stalls = 1'b0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;

    bounded_list_insert_delete_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_entry_value    (s_entry_value),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_elem_value     (m_elem_value),
        .m_last_flag      (m_last_flag),
        .m_list_empty     (m_list_empty),
        .m_insert_dropped (m_insert_dropped)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic signed [VAL_W-1:0] got,
                                   input logic signed [VAL_W-1:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch on %s at result %0d: got %0d, wanted %0d",
                     $time, what, results_checked, got, want);
        mismatch_count++;
    endtask

    // Apply one request to the predicted list and queue the listing it causes
    function automatic void predict_listing(input logic [REQ_W-1:0] kind,
                                            input logic signed [VAL_W-1:0] value,
                                            input logic [POS_W-1:0] pos);
        logic           dropped;
        listing_entry_t entry;
        int             n;
        dropped = 1'b0;
        case (kind) inside
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (list_model.size() >= LIST_DEPTH)
                    dropped = 1'b1;
                else if (kind == REQ_INS_FRONT)
                    list_model.push_front(value);
                else
                    list_model.push_back(value);
            end
            REQ_DELETE: begin
                if (int'(pos) < list_model.size())
                    list_model.delete(int'(pos));
            end
            default: ;
        endcase
        if (dropped)
            drops_predicted++;
        n = list_model.size();
        if (n > peak_count)
            peak_count = n;
        if (n == 0) begin
            entry = '{value: '0, last: 1'b1, empty: 1'b1, dropped: dropped};
            listing_q.push_back(entry);
        end else begin
            for (int i = 0; i < n; i++) begin
                entry = '{value: list_model[i], last: (i == n - 1), empty: 1'b0,
                          dropped: dropped};
                listing_q.push_back(entry);
            end
        end
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Extremes and small values now and then, otherwise any 32-bit pattern
    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 20)) - 10;
            default: return $urandom();
        endcase
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic signed [VAL_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= kind;
        s_entry_value <= value;
        s_position    <= pos;
        do @(posedge aclk); while (!s_ready);
        predict_listing(kind, value, pos);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (listing_q.size() != 0) @(posedge aclk);
    endtask

    // Result checker
    always @(posedge aclk) begin
        listing_entry_t want;
        if (aresetn && m_valid && m_ready) begin
            if (listing_q.size() == 0) begin
                report_mismatch("unexpected result", m_elem_value, '0);
            end else begin
                want = listing_q.pop_front();
                if (m_elem_value !== want.value)
                    report_mismatch("elem_value", m_elem_value, want.value);
                if (m_last_flag !== want.last)
                    report_mismatch("last_flag", VAL_W'(m_last_flag), VAL_W'(want.last));
                if (m_list_empty !== want.empty)
                    report_mismatch("list_empty", VAL_W'(m_list_empty), VAL_W'(want.empty));
                if (m_insert_dropped !== want.dropped)
                    report_mismatch("insert_dropped", VAL_W'(m_insert_dropped),
                                    VAL_W'(want.dropped));
            end
            results_checked++;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(10, 40);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Special cases back to back, both sides always ready
    task automatic test_directed();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        send_request(REQ_DELETE, 32'sd0, 6'd0);
        send_request(REQ_UNUSED, pick_value(), 6'd63);
        send_request(REQ_INS_FRONT, 32'sh7FFF_FFFF, 6'd0);
        send_request(REQ_INS_BACK, 32'sh8000_0000, 6'd63);
        send_request(REQ_INS_FRONT, 32'sd0, 6'd5);
        send_request(REQ_INS_BACK, -32'sd1, 6'd0);
        // positions out of range leave the list alone
        send_request(REQ_DELETE, pick_value(), 6'd63);
        send_request(REQ_DELETE, 32'sd0, POS_W'(list_model.size()));
        send_request(REQ_DELETE, 32'sd0, 6'd1);
        send_request(REQ_UNUSED, pick_value(), 6'($urandom_range(0, 63)));
        send_request(REQ_INS_BACK, 32'sh5555_5555, 6'd42);
        send_request(REQ_INS_FRONT, 32'shAAAA_AAAA, 6'd21);
        send_request(REQ_DELETE, 32'sd0, POS_W'(list_model.size() - 1));
        // empty it from the front, then delete on empty again
        while (list_model.size() > 0)
            send_request(REQ_DELETE, pick_value(), 6'd0);
        send_request(REQ_DELETE, 32'sd0, 6'd0);
        send_request(REQ_INS_BACK, 32'sd1, 6'd0);
        send_request(REQ_DELETE, 32'sd0, 6'd0);
        wait_drained();
    endtask

    // Fill to the bound, try inserts that must be dropped, then empty again
    task automatic test_full_list();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        while (list_model.size() < LIST_DEPTH)
            send_request($urandom_range(0, 1) ? REQ_INS_FRONT : REQ_INS_BACK,
                         pick_value(), 6'($urandom_range(0, 63)));
        send_request(REQ_INS_FRONT, pick_value(), 6'd0);
        send_request(REQ_INS_BACK, pick_value(), 6'd0);
        send_request(REQ_DELETE, 32'sd0, 6'd63);
        send_request(REQ_DELETE, 32'sd0, POS_W'(LIST_DEPTH - 1));
        send_request(REQ_INS_BACK, 32'sh7FFF_FFFF, 6'd0);
        send_request(REQ_INS_FRONT, 32'sh8000_0000, 6'd0);
        while (list_model.size() > 0)
            send_request(REQ_DELETE, pick_value(),
                         6'($urandom_range(0, list_model.size() - 1)));
        wait_drained();
    endtask

    // Random walk of the fill level, growing and shrinking in turn
    task automatic test_random(input int n_items);
        bit               growing;
        int               r;
        logic [REQ_W-1:0] kind;
        logic [POS_W-1:0] pos;
        growing = 1'b1;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2) begin
                // a quiet stretch on both sides
                tx_gaps = 1'b0;
                rx_stalls = 1'b0;
            end else if (k == (3 * n_items) / 4) begin
                tx_gaps = 1'b1;
                rx_stalls = 1'b1;
            end
            if (list_model.size() == LIST_DEPTH && $urandom_range(0, 2) == 0)
                growing = 1'b0;
            else if (list_model.size() == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                growing = !growing;
            r = $urandom_range(0, 99);
            if (r < 3)
                kind = REQ_UNUSED;
            else if (r < (growing ? 78 : 28))
                kind = $urandom_range(0, 1) ? REQ_INS_FRONT : REQ_INS_BACK;
            else
                kind = REQ_DELETE;
            if (kind == REQ_DELETE && list_model.size() > 0 && $urandom_range(0, 4) != 0)
                pos = POS_W'($urandom_range(0, list_model.size() - 1));
            else
                pos = POS_W'($urandom_range(0, 63));
            send_request(kind, pick_value(), pos);
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        hold_request = 1'b1;
        for (int k = 0; k < 20; k++)
            send_request((k % 5 == 4) ? REQ_DELETE
                                      : ($urandom_range(0, 1) ? REQ_INS_FRONT : REQ_INS_BACK),
                         pick_value(), 6'($urandom_range(0, 63)));
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_list();
        test_random(150);
        test_backpressure();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (listing_q.size() != 0)
            report_mismatch("results never delivered", listing_q.size(), 0);
        $display("Sent %0d requests and checked %0d listed entries; %0d inserts refused.",
                 items_sent, results_checked, drops_predicted);
        $display("Fill level peaked at %0d of %0d; %0d mismatches.",
                 peak_count, LIST_DEPTH, mismatch_count);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
